// ===== design/osm_pkg.sv =====
// ----------------------------------------------------------------------------
// osm_pkg: shared types and codes of the order statistic multiset
// Holds the mode and status codes used by the sequencer and the top level.
// ----------------------------------------------------------------------------
package osm_pkg;
	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_REMOVE = 3'd1;
	localparam logic [2:0] MODE_RANK   = 3'd2;
	localparam logic [2:0] MODE_SELECT = 3'd3;
	localparam logic [2:0] MODE_PRED   = 3'd4;
	localparam logic [2:0] MODE_SUCC   = 3'd5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NONE   = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	localparam int TOTAL_BITS = 24;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] answer;
	} osm_result_t;
endpackage

// ===== design/osm_store.sv =====
// ----------------------------------------------------------------------------
// osm_store: single-port value and count memory
// One read or one write per cycle, read data registered.
// ----------------------------------------------------------------------------
module osm_store #(
	parameter int CAPACITY   = 256,
	parameter int COUNT_BITS = 16,
	parameter int AW         = 8
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         addr,
	input  logic [31:0]           wvalue,
	input  logic [COUNT_BITS-1:0] wcount,
	output logic [31:0]           rvalue,
	output logic [COUNT_BITS-1:0] rcount
);
	logic [31+COUNT_BITS:0] mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= {wcount, wvalue};
		end
		{rcount, rvalue} <= mem_q[addr];
	end
endmodule

// ===== design/order_statistic_multiset.sv =====
// ----------------------------------------------------------------------------
// order_statistic_multiset: sorted multiset with rank and select
// Sequencer over one entry memory and one shared compare/add datapath.
// ----------------------------------------------------------------------------
// The block keeps distinct signed values in ascending memory slots, each with
// a repeat count. An item is one mode plus one value; each item gives exactly
// one result. The sequencer walks the slots through a single memory port with
// registered read data, one slot at a time (address, then data). A scan of
// the live entries finds the position and builds the prefix sum of counts.
// An insert of a new value then moves every entry from the position up one
// slot (read then write for each entry) and writes the new entry; a remove
// that empties an entry moves the entries above it down the same way. The
// block takes no new item until the last result is taken: s_tready is high
// only while idle. The result is held in an output register until taken.
module order_statistic_multiset #(
	parameter int CAPACITY   = 256,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [2:0] mode, [34:3] value, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // [31:0] answer, [33:32] status, zero fill
);
	import osm_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int UW = $clog2(CAPACITY + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;  // address issued, data next cycle
	localparam logic [2:0] S_SCAN = 3'd2;  // examine data of slot idx
	localparam logic [2:0] S_DONE = 3'd3;  // decide result and update
	localparam logic [2:0] S_MVRD = 3'd4;  // read source of a move
	localparam logic [2:0] S_MVWR = 3'd5;  // write destination of a move
	localparam logic [2:0] S_OUT  = 3'd6;
	localparam logic [2:0] S_SET  = 3'd7;  // write value and count at pos

	logic [2:0]            state_q;
	logic [2:0]            mode_q;
	logic signed [31:0]    val_q;
	logic [UW-1:0]         used_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [UW-1:0]         idx_q;      // slot being scanned
	logic [UW-1:0]         pos_q;      // first slot not below value
	logic                  pos_ok_q;   // pos settled
	logic                  found_q;
	logic [COUNT_BITS-1:0] fcnt_q;     // count at pos
	logic signed [31:0]    predv_q;    // value at pos-1
	logic signed [31:0]    succv_q;    // value at first slot above value
	logic                  succ_ok_q;
	logic [TOTAL_BITS-1:0] smaller_q;  // prefix sum below pos
	logic [TOTAL_BITS-1:0] acc_q;      // running prefix sum for select
	logic signed [31:0]    selv_q;
	logic                  sel_ok_q;
	logic [UW-1:0]         mv_q;       // move source cursor
	logic                  mvup_q;
	logic [UW-1:0]         mvend_q;    // last source slot of the move
	logic signed [31:0]    mvval_q;
	logic [COUNT_BITS-1:0] mvcnt_q;
	osm_result_t           res_q;

	// memory port
	logic                  mem_we;
	logic [AW-1:0]         mem_addr;
	logic [31:0]           mem_wv;
	logic [COUNT_BITS-1:0] mem_wc;
	logic signed [31:0]    rv;
	logic [COUNT_BITS-1:0] rc;
	logic [UW-1:0]         mv_dst;     // destination of the moved entry

	osm_store #(.CAPACITY(CAPACITY), .COUNT_BITS(COUNT_BITS), .AW(AW)) u_store (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wvalue(mem_wv), .wcount(mem_wc),
		.rvalue(rv), .rcount(rc)
	);

	// shared datapath: one compare against the operand, one prefix add
	logic                  lt_v;
	logic [TOTAL_BITS-1:0] acc_next;
	logic [31:0]           kval;
	assign lt_v     = rv < val_q;
	assign acc_next = acc_q + TOTAL_BITS'(rc);
	assign kval     = val_q;

	// up moves go one slot higher, down moves one slot lower
	assign mv_dst = mvup_q ? mv_q + 1'b1 : mv_q - 1'b1;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {6'd0, res_q.status, res_q.answer};

	// memory address and write data
	always_comb begin
		mem_we   = 1'b0;
		mem_addr = idx_q[AW-1:0];
		mem_wv   = rv;
		mem_wc   = rc;
		unique case (state_q)
			S_MVRD: mem_addr = mv_q[AW-1:0];
			S_MVWR: begin
				// entry read in the source cycle is on rv/rc now
				mem_we   = 1'b1;
				mem_addr = mv_dst[AW-1:0];
			end
			S_SET: begin
				mem_we   = 1'b1;
				mem_addr = pos_q[AW-1:0];
				mem_wv   = mvval_q;
				mem_wc   = mvcnt_q;
			end
			default: mem_addr = idx_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			total_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q    <= s_tdata[2:0];
						val_q     <= s_tdata[34:3];
						idx_q     <= '0;
						pos_q     <= used_q;
						pos_ok_q  <= 1'b0;
						found_q   <= 1'b0;
						fcnt_q    <= '0;
						succ_ok_q <= 1'b0;
						smaller_q <= '0;
						acc_q     <= '0;
						sel_ok_q  <= 1'b0;
						state_q   <= (used_q == '0) ? S_DONE : S_RD;
					end
				end
				S_RD: state_q <= S_SCAN;
				S_SCAN: begin
					// slot idx_q data now on rv/rc
					if (!pos_ok_q) begin
						if (lt_v) begin
							predv_q   <= rv;
							smaller_q <= acc_next;
						end else begin
							pos_q    <= idx_q;
							pos_ok_q <= 1'b1;
							found_q  <= (rv == val_q);
							fcnt_q   <= rc;
							if (rv != val_q) begin
								succv_q   <= rv;
								succ_ok_q <= 1'b1;
							end
						end
					end else if (!succ_ok_q) begin
						succv_q   <= rv;
						succ_ok_q <= 1'b1;
					end
					if (!sel_ok_q && ({8'd0, acc_next} >= kval)) begin
						selv_q   <= rv;
						sel_ok_q <= 1'b1;
					end
					acc_q <= acc_next;
					if (idx_q + 1'b1 == used_q) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					res_q.answer <= '0;
					res_q.status <= ST_OK;
					state_q      <= S_OUT;
					unique case (mode_q)
						MODE_INSERT: begin
							if (total_q == TOTAL_MAX) begin
								res_q.status <= ST_FULL;
							end else if (found_q) begin
								if (fcnt_q == CNT_MAX) begin
									res_q.status <= ST_FULL;
								end else begin
									total_q <= total_q + 1'b1;
									mvval_q <= val_q;
									mvcnt_q <= fcnt_q + 1'b1;
									state_q <= S_SET;
								end
							end else if (used_q == UW'(CAPACITY)) begin
								res_q.status <= ST_FULL;
							end else begin
								total_q <= total_q + 1'b1;
								used_q  <= used_q + 1'b1;
								mvval_q <= val_q;
								mvcnt_q <= COUNT_BITS'(1);
								if (used_q == pos_q) begin
									state_q <= S_SET;
								end else begin
									// copy slot mv to mv+1, top down to pos
									mvup_q  <= 1'b1;
									mv_q    <= used_q - 1'b1;
									mvend_q <= pos_q;
									state_q <= S_MVRD;
								end
							end
						end
						MODE_REMOVE: begin
							if (!found_q) begin
								res_q.status <= ST_ABSENT;
							end else begin
								if (total_q != '0) total_q <= total_q - 1'b1;
								if (fcnt_q != COUNT_BITS'(1)) begin
									mvval_q <= val_q;
									mvcnt_q <= fcnt_q - 1'b1;
									state_q <= S_SET;
								end else begin
									used_q <= used_q - 1'b1;
									if (pos_q + 1'b1 != used_q) begin
										// copy slot mv to mv-1, bottom up
										mvup_q  <= 1'b0;
										mv_q    <= pos_q + 1'b1;
										mvend_q <= used_q - 1'b1;
										state_q <= S_MVRD;
									end
								end
							end
						end
						MODE_RANK: res_q.answer <= 32'(smaller_q) + 32'd1;
						MODE_SELECT: begin
							if ($signed(val_q) < 1 || kval > {8'd0, total_q} || !sel_ok_q)
								res_q.status <= ST_NONE;
							else
								res_q.answer <= selv_q;
						end
						MODE_PRED: begin
							if (pos_q == '0) res_q.status <= ST_NONE;
							else res_q.answer <= predv_q;
						end
						MODE_SUCC: begin
							if (!succ_ok_q) res_q.status <= ST_NONE;
							else res_q.answer <= succv_q;
						end
						default: res_q.status <= ST_NONE;
					endcase
				end
				S_MVRD: state_q <= S_MVWR;
				S_MVWR: begin
					if (mv_q == mvend_q) begin
						// an insert still owes the new entry at pos
						state_q <= mvup_q ? S_SET : S_OUT;
					end else begin
						mv_q    <= mvup_q ? mv_q - 1'b1 : mv_q + 1'b1;
						state_q <= S_MVRD;
					end
				end
				S_SET: state_q <= S_OUT;
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
